>>> design/ptst_pkg.sv
// Package for the periodic tick scheduler table.
// Types, widths and codes shared by the interfaces and all modules.
// No dependencies.
package ptst_pkg;

  localparam int ID_W   = 16;
  localparam int IVAL_W = 16;
  localparam int VAL_W  = 15;
  localparam int CMD_W  = 2;
  localparam int KIND_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK  = 2'd0,
    CMD_SET   = 2'd1,
    CMD_QUERY = 2'd2
  } cmd_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_FIRE  = 2'd0,
    KIND_TICK  = 2'd1,
    KIND_SET   = 2'd2,
    KIND_QUERY = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_TICK_DONE,
    ST_FIND,
    ST_APPLY,
    ST_MOVE,
    ST_REPLY
  } st_e;

  typedef struct packed {
    logic [ID_W-1:0]   client;
    logic [IVAL_W-1:0] countdown;
    logic [IVAL_W-1:0] period;
    logic              handler;
  } entry_t;

  typedef struct packed {
    kind_e             kind;
    logic [ID_W-1:0]   client;
    logic [VAL_W-1:0]  value;
    logic              last;
  } res_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } tbl_ctl_t;

endpackage

>>> design/ptst_if.sv
// Request and result channel interfaces (valid/ready handshake).
// Depends on ptst_pkg.
interface ptst_req_if;
  logic                                valid;
  logic                                ready;
  logic [ptst_pkg::CMD_W-1:0]          cmd;
  logic [ptst_pkg::ID_W-1:0]           client_id;
  logic signed [ptst_pkg::IVAL_W-1:0]  interval;
  logic                                has_handler;
  logic                                is_destroyed;

  modport source (output valid, cmd, client_id, interval, has_handler, is_destroyed,
                  input ready);
  modport sink   (input valid, cmd, client_id, interval, has_handler, is_destroyed,
                  output ready);
endinterface

interface ptst_res_if;
  logic                          valid;
  logic                          ready;
  logic [ptst_pkg::KIND_W-1:0]   kind;
  logic [ptst_pkg::ID_W-1:0]     client_id_res;
  logic [ptst_pkg::VAL_W-1:0]    value;
  logic                          last;

  modport source (output valid, kind, client_id_res, value, last, input ready);
  modport sink   (input valid, kind, client_id_res, value, last, output ready);
endinterface

>>> design/ptst_table.sv
// Entry table: one write port, one read port with registered read data.
// Depends on ptst_pkg.
module ptst_table #(
  parameter int ENTRIES = 32,
  parameter int IW      = 5
) (
  input  logic                clk_i,
  input  ptst_pkg::tbl_ctl_t  ctl_i,
  input  logic [IW-1:0]       waddr_i,
  input  ptst_pkg::entry_t    wdata_i,
  input  logic [IW-1:0]       raddr_i,
  output ptst_pkg::entry_t    rdata_o
);

  ptst_pkg::entry_t mem_q [ENTRIES];
  ptst_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // read data holds while no read is issued
    if (ctl_i.rd_en) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/ptst_out.sv
// Result output register between the sequencer and the result channel.
// Depends on ptst_pkg and ptst_if.
module ptst_out (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             res_valid_i,
  input  ptst_pkg::res_t   res_i,
  output logic             res_ready_o,
  ptst_res_if.source       res_o
);

  logic           valid_q, valid_d;
  ptst_pkg::res_t data_q;
  logic           load;

  assign res_ready_o = !valid_q || res_o.ready;
  assign load        = res_valid_i && res_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (res_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= res_i;
    end
  end

  assign res_o.valid         = valid_q;
  assign res_o.kind          = data_q.kind;
  assign res_o.client_id_res = data_q.client;
  assign res_o.value         = data_q.value;
  assign res_o.last          = data_q.last;

endmodule

>>> design/ptst_seq.sv
// Sequencer: walks, searches and compacts the entry table one entry a cycle, unless a
// firing entry waits on the result side. Depends on ptst_pkg and ptst_if; drives ptst_table and ptst_out.
module ptst_seq #(
  parameter int ENTRIES = 32,
  parameter int IW      = 5,
  parameter int CW      = 6
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                beat_enable_i,
  ptst_req_if.sink            req_i,
  output ptst_pkg::tbl_ctl_t  tbl_ctl_o,
  output logic [IW-1:0]       waddr_o,
  output ptst_pkg::entry_t    wdata_o,
  output logic [IW-1:0]       raddr_o,
  input  ptst_pkg::entry_t    rdata_i,
  output logic                res_valid_o,
  output ptst_pkg::res_t      res_o,
  input  logic                res_ready_i
);

  localparam int XW = CW + 1;

  ptst_pkg::st_e  state_q, state_d;
  logic [IW-1:0]  idx_q, idx_d;
  logic [CW-1:0]  count_q, count_d;
  logic [CW-1:0]  fires_q, fires_d;
  logic           found_q, found_d;
  logic [ptst_pkg::VAL_W-1:0] val_q, val_d;

  // request fields held for the duration of the item
  ptst_pkg::cmd_e               cmd_q;
  logic [ptst_pkg::ID_W-1:0]    id_q;
  logic [ptst_pkg::IVAL_W-1:0]  ival_q;
  logic                         hnd_q;

  logic                         accept;
  logic [XW-1:0]                idx_x, cnt_x;
  logic [ptst_pkg::IVAL_W-1:0]  cd;
  logic                         fire;
  logic                         id_hit;
  logic                         ival_zero, ival_neg;

  assign req_i.ready = (state_q == ptst_pkg::ST_IDLE);
  assign accept      = req_i.valid && req_i.ready;

  assign idx_x     = XW'(idx_q);
  assign cnt_x     = XW'(count_q);
  assign cd        = rdata_i.countdown - ptst_pkg::IVAL_W'(1);
  assign fire      = rdata_i.handler && ((cd == '0) || cd[ptst_pkg::IVAL_W-1]);
  assign id_hit    = (rdata_i.client == id_q);
  assign ival_zero = (ival_q == '0);
  assign ival_neg  = ival_q[ptst_pkg::IVAL_W-1];

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= ptst_pkg::cmd_e'(req_i.cmd);
      id_q   <= req_i.client_id;
      ival_q <= req_i.interval;
      hnd_q  <= req_i.has_handler;
    end
  end

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    count_d     = count_q;
    fires_d     = fires_q;
    found_d     = found_q;
    val_d       = val_q;
    tbl_ctl_o   = '0;
    waddr_o     = idx_q;
    raddr_o     = idx_q;
    wdata_o     = rdata_i;
    res_valid_o = 1'b0;
    res_o       = '{kind: ptst_pkg::KIND_FIRE, client: '0, value: '0, last: 1'b0};

    case (state_q)
      ptst_pkg::ST_IDLE: begin
        if (accept) begin
          case (ptst_pkg::cmd_e'(req_i.cmd))
            ptst_pkg::CMD_TICK: begin
              fires_d = '0;
              if (beat_enable_i && (count_q != '0)) begin
                tbl_ctl_o.rd_en = 1'b1;
                raddr_o         = '0;
                idx_d           = '0;
                state_d         = ptst_pkg::ST_WALK;
              end else begin
                state_d = ptst_pkg::ST_TICK_DONE;
              end
            end
            ptst_pkg::CMD_SET, ptst_pkg::CMD_QUERY: begin
              if ((ptst_pkg::cmd_e'(req_i.cmd) == ptst_pkg::CMD_SET) &&
                  req_i.is_destroyed) begin
                val_d   = '0;
                state_d = ptst_pkg::ST_REPLY;
              end else if (count_q != '0) begin
                // search from the top: the last matching entry wins
                tbl_ctl_o.rd_en = 1'b1;
                raddr_o         = IW'(count_q - CW'(1));
                idx_d           = IW'(count_q - CW'(1));
                state_d         = ptst_pkg::ST_FIND;
              end else begin
                found_d = 1'b0;
                state_d = ptst_pkg::ST_APPLY;
              end
            end
            default: begin
              state_d = ptst_pkg::ST_IDLE;
            end
          endcase
        end
      end

      ptst_pkg::ST_WALK: begin
        if (!fire || res_ready_i) begin
          tbl_ctl_o.wr_en = 1'b1;
          waddr_o         = idx_q;
          wdata_o.countdown = fire ? rdata_i.period : cd;
          if (fire) begin
            res_valid_o  = 1'b1;
            res_o.kind   = ptst_pkg::KIND_FIRE;
            res_o.client = rdata_i.client;
            fires_d      = fires_q + CW'(1);
          end
          if ((idx_x + XW'(1)) == cnt_x) begin
            state_d = ptst_pkg::ST_TICK_DONE;
          end else begin
            tbl_ctl_o.rd_en = 1'b1;
            raddr_o         = IW'(idx_x + XW'(1));
            idx_d           = IW'(idx_x + XW'(1));
          end
        end
      end

      ptst_pkg::ST_TICK_DONE: begin
        res_valid_o = 1'b1;
        res_o.kind  = ptst_pkg::KIND_TICK;
        res_o.value = ptst_pkg::VAL_W'(fires_q);
        res_o.last  = 1'b1;
        if (res_ready_i) begin
          state_d = ptst_pkg::ST_IDLE;
        end
      end

      ptst_pkg::ST_FIND: begin
        if (id_hit) begin
          found_d = 1'b1;
          state_d = ptst_pkg::ST_APPLY;
        end else if (idx_q == '0) begin
          found_d = 1'b0;
          state_d = ptst_pkg::ST_APPLY;
        end else begin
          tbl_ctl_o.rd_en = 1'b1;
          raddr_o         = idx_q - IW'(1);
          idx_d           = idx_q - IW'(1);
        end
      end

      ptst_pkg::ST_APPLY: begin
        state_d = ptst_pkg::ST_REPLY;
        val_d   = '0;
        if (cmd_q == ptst_pkg::CMD_QUERY) begin
          if (found_q) begin
            val_d = rdata_i.period[ptst_pkg::VAL_W-1:0];
          end
        end else if (ival_zero) begin
          if (found_q) begin
            if ((idx_x + XW'(1)) < cnt_x) begin
              tbl_ctl_o.rd_en = 1'b1;
              raddr_o         = IW'(idx_x + XW'(1));
              state_d         = ptst_pkg::ST_MOVE;
            end else begin
              count_d = count_q - CW'(1);
              val_d   = ptst_pkg::VAL_W'(1);
            end
          end
        end else if (found_q) begin
          if (!ival_neg) begin
            tbl_ctl_o.wr_en   = 1'b1;
            waddr_o           = idx_q;
            wdata_o.period    = ival_q;
            wdata_o.countdown = ival_q;
            val_d             = ptst_pkg::VAL_W'(1);
          end
        end else if (cnt_x < XW'(ENTRIES)) begin
          tbl_ctl_o.wr_en   = 1'b1;
          waddr_o           = IW'(count_q);
          wdata_o.client    = id_q;
          wdata_o.period    = ival_neg ? ptst_pkg::IVAL_W'(1) : ival_q;
          wdata_o.countdown = ival_neg ? ptst_pkg::IVAL_W'(1) : ival_q;
          wdata_o.handler   = hnd_q;
          count_d           = count_q + CW'(1);
          val_d             = ptst_pkg::VAL_W'(1);
        end
      end

      ptst_pkg::ST_MOVE: begin
        // read data holds entry idx+1; shift it down one place
        tbl_ctl_o.wr_en = 1'b1;
        waddr_o         = idx_q;
        if ((idx_x + XW'(2)) < cnt_x) begin
          tbl_ctl_o.rd_en = 1'b1;
          raddr_o         = IW'(idx_x + XW'(2));
          idx_d           = IW'(idx_x + XW'(1));
        end else begin
          count_d = count_q - CW'(1);
          val_d   = ptst_pkg::VAL_W'(1);
          state_d = ptst_pkg::ST_REPLY;
        end
      end

      ptst_pkg::ST_REPLY: begin
        res_valid_o  = 1'b1;
        res_o.kind   = (cmd_q == ptst_pkg::CMD_QUERY) ? ptst_pkg::KIND_QUERY
                                                      : ptst_pkg::KIND_SET;
        res_o.client = id_q;
        res_o.value  = val_q;
        res_o.last   = 1'b1;
        if (res_ready_i) begin
          state_d = ptst_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = ptst_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ptst_pkg::ST_IDLE;
      count_q <= '0;
      idx_q   <= '0;
      fires_q <= '0;
      found_q <= 1'b0;
      val_q   <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      idx_q   <= idx_d;
      fires_q <= fires_d;
      found_q <= found_d;
      val_q   <= val_d;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(ENTRIES))
    else $error("entry count exceeds table size");

  a_no_port_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tbl_ctl_o.wr_en && tbl_ctl_o.rd_en) |-> (waddr_o != raddr_o))
    else $error("read and write to the same entry in one cycle");

  a_walk_keeps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ptst_pkg::ST_WALK) |=> (count_q == $past(count_q)))
    else $error("entry count changed during a tick walk");

  a_last_ends_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_ready_i && res_o.last) |=> (state_q == ptst_pkg::ST_IDLE))
    else $error("final result did not return the sequencer to idle");

endmodule

>>> design/periodic_tick_scheduler_table_top.sv
// Channel   Dir  Handshake     Payload
// req_i     in   valid/ready   cmd, client_id, interval, has_handler, is_destroyed
// res_o     out  valid/ready   kind, client_id_res, value, last
// cfg       in   cfg_we_i      cfg_wdata_i (beat_enable)
//
// A tick walks the N table entries one entry a cycle through the single table read
// port, unless a firing entry waits on a result stall. Set and query search from the
// top, one entry a cycle; a remove then compacts the table at one entry a cycle.
// Reset clears the entry count and the sequencer state but not the table; no clearing
// pass. The request is taken only while the sequencer is idle. Depends on ptst_pkg,
// ptst_if and submodules.
module periodic_tick_scheduler_table_top #(
  parameter int ENTRIES = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  ptst_req_if.sink    req_i,
  ptst_res_if.source  res_o
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);

  logic               beat_enable_q;
  ptst_pkg::tbl_ctl_t tbl_ctl;
  logic [IW-1:0]      waddr, raddr;
  ptst_pkg::entry_t   wdata, rdata;
  logic               res_valid, res_ready;
  ptst_pkg::res_t     res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_enable_q <= 1'b1;
    end else if (cfg_we_i) begin
      beat_enable_q <= cfg_wdata_i;
    end
  end

  ptst_seq #(
    .ENTRIES (ENTRIES),
    .IW      (IW),
    .CW      (CW)
  ) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .beat_enable_i (beat_enable_q),
    .req_i         (req_i),
    .tbl_ctl_o     (tbl_ctl),
    .waddr_o       (waddr),
    .wdata_o       (wdata),
    .raddr_o       (raddr),
    .rdata_i       (rdata),
    .res_valid_o   (res_valid),
    .res_o         (res),
    .res_ready_i   (res_ready)
  );

  ptst_table #(
    .ENTRIES (ENTRIES),
    .IW      (IW)
  ) u_table (
    .clk_i   (clk_i),
    .ctl_i   (tbl_ctl),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  ptst_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .res_ready_o (res_ready),
    .res_o       (res_o)
  );

endmodule

>>> tb/periodic_tick_scheduler_table_top_tb.sv
// Self-checking testbench for periodic_tick_scheduler_table_top.
// The scoreboard class tracks the timer table, predicts every reply and checks each one.
// Depends on ptst_pkg, ptst_if and the design sources.

class beat_schedule_tracker;
  localparam int unsigned SLOTS = 32;
  localparam int unsigned SHOWN = 10;

  logic [ptst_pkg::ID_W-1:0]   slot_client[SLOTS];
  logic [ptst_pkg::IVAL_W-1:0] slot_countdown[SLOTS];
  logic [ptst_pkg::IVAL_W-1:0] slot_period[SLOTS];
  logic                        slot_handler[SLOTS];
  int unsigned                 slots_used;
  logic                        beats_on;
  ptst_pkg::res_t              expected_replies[$];
  int unsigned                 bad_replies;

  function new();
    slots_used  = 0;
    beats_on    = 1'b1;
    bad_replies = 0;
  endfunction

  function int unsigned pending();
    return expected_replies.size();
  endfunction

  // last slot holding the client, -1 when absent
  function int find_slot(logic [ptst_pkg::ID_W-1:0] id);
    for (int i = int'(slots_used) - 1; i >= 0; i--)
      if (slot_client[i] == id) return i;
    return -1;
  endfunction

  function ptst_pkg::res_t reply(ptst_pkg::kind_e kind, logic [ptst_pkg::ID_W-1:0] id,
                                 logic [ptst_pkg::VAL_W-1:0] value, logic last);
    ptst_pkg::res_t r;
    r.kind   = kind;
    r.client = id;
    r.value  = value;
    r.last   = last;
    return r;
  endfunction

  function void take_request(logic [ptst_pkg::CMD_W-1:0] cmd,
                             logic [ptst_pkg::ID_W-1:0] id,
                             logic [ptst_pkg::IVAL_W-1:0] ival, logic hnd, logic dstr);
    int                          idx;
    int unsigned                 fires;
    logic [ptst_pkg::IVAL_W-1:0] cd;
    logic                        ok;
    idx   = find_slot(id);
    fires = 0;
    ok    = 1'b0;
    case (cmd)
      ptst_pkg::CMD_TICK: begin
        if (beats_on) begin
          for (int i = 0; i < int'(slots_used); i++) begin
            cd = slot_countdown[i] - 1'b1;
            // fires once the countdown, read signed, drops below one
            if (slot_handler[i] && (cd == '0 || cd[ptst_pkg::IVAL_W-1])) begin
              cd = slot_period[i];
              expected_replies.push_back(reply(ptst_pkg::KIND_FIRE, slot_client[i],
                                               '0, 1'b0));
              fires++;
            end
            slot_countdown[i] = cd;
          end
        end
        expected_replies.push_back(reply(ptst_pkg::KIND_TICK, '0,
                                         ptst_pkg::VAL_W'(fires), 1'b1));
      end
      ptst_pkg::CMD_SET: begin
        if (!dstr) begin
          if (ival == '0) begin
            if (idx >= 0) begin
              for (int j = idx; j + 1 < int'(slots_used); j++) begin
                slot_client[j]    = slot_client[j+1];
                slot_countdown[j] = slot_countdown[j+1];
                slot_period[j]    = slot_period[j+1];
                slot_handler[j]   = slot_handler[j+1];
              end
              slots_used--;
              ok = 1'b1;
            end
          end else if (idx >= 0) begin
            if (!ival[ptst_pkg::IVAL_W-1]) begin
              slot_period[idx]    = ival;
              slot_countdown[idx] = ival;
              ok = 1'b1;
            end
          end else if (slots_used < SLOTS) begin
            slot_client[slots_used]    = id;
            slot_period[slots_used]    = ival[ptst_pkg::IVAL_W-1] ?
                                         ptst_pkg::IVAL_W'(1) : ival;
            slot_countdown[slots_used] = ival[ptst_pkg::IVAL_W-1] ?
                                         ptst_pkg::IVAL_W'(1) : ival;
            slot_handler[slots_used]   = hnd;
            slots_used++;
            ok = 1'b1;
          end
        end
        expected_replies.push_back(reply(ptst_pkg::KIND_SET, id,
                                         ptst_pkg::VAL_W'(ok), 1'b1));
      end
      ptst_pkg::CMD_QUERY: begin
        expected_replies.push_back(
          reply(ptst_pkg::KIND_QUERY, id,
                (idx >= 0) ? slot_period[idx][ptst_pkg::VAL_W-1:0] : '0, 1'b1));
      end
      default: ;  // unused code: dropped without a reply
    endcase
  endfunction

  function void check_reply(ptst_pkg::res_t got);
    ptst_pkg::res_t want;
    if (expected_replies.size() == 0) begin
      bad_replies++;
      if (bad_replies <= SHOWN)
        $display("unexpected reply: kind %0d client %h value %0d last %0b",
                 got.kind, got.client, got.value, got.last);
      return;
    end
    want = expected_replies.pop_front();
    if (got.kind !== want.kind || got.client !== want.client ||
        got.value !== want.value || got.last !== want.last) begin
      bad_replies++;
      if (bad_replies <= SHOWN)
        $display({"reply mismatch: expected kind %0d client %h value %0d last %0b,",
                  " got kind %0d client %h value %0d last %0b"},
                 want.kind, want.client, want.value, want.last,
                 got.kind, got.client, got.value, got.last);
    end
  endfunction
endclass

module periodic_tick_scheduler_table_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ENTRIES       = 32;
  localparam int CLK_PERIOD    = 20;
  localparam int ID_POOL       = 10;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 2 * ENTRIES + 16;
  // silence allowed: long hold-off plus a full walk plus the settle time, with margin
  localparam int QUIET_LIMIT   = 4000;
  localparam logic [ptst_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [ptst_pkg::CMD_W-1:0]  cmd;
    logic [ptst_pkg::ID_W-1:0]   id;
    logic [ptst_pkg::IVAL_W-1:0] ival;
    logic                        hnd;
    logic                        dstr;
  } sched_req_t;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic cfg_we_i    = 1'b0;
  logic cfg_wdata_i = 1'b0;

  int unsigned send_idle_pct = 0;
  int unsigned res_stall_pct = 0;
  bit          hold_res      = 1'b0;
  int          quiet_cycles  = 0;

  logic [ptst_pkg::ID_W-1:0] id_pool[ID_POOL];

  beat_schedule_tracker tracker;

  ptst_req_if req_if ();
  ptst_res_if res_if ();

  periodic_tick_scheduler_table_top #(
    .ENTRIES (ENTRIES)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_if),
    .res_o       (res_if)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  always @(posedge clk_i) begin : reply_monitor
    ptst_pkg::res_t got;
    if (rst_ni) begin
      if (res_if.valid && res_if.ready) begin
        got.kind   = ptst_pkg::kind_e'(res_if.kind);
        got.client = res_if.client_id_res;
        got.value  = res_if.value;
        got.last   = res_if.last;
        tracker.check_reply(got);
      end
      if ((res_if.valid && res_if.ready) || (req_if.valid && req_if.ready))
        quiet_cycles = 0;
      else
        quiet_cycles = quiet_cycles + 1;
    end
  end

  // reply side: random stalls, plus one long hold-off counted here
  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_res) begin
        res_if.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_res = 1'b0;
      end
      res_if.ready = ($urandom_range(99) >= res_stall_pct);
    end
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
    $display("end of test: mismatches");
    $finish;
  end

  function automatic sched_req_t make_req(logic [ptst_pkg::CMD_W-1:0] cmd,
                                          logic [ptst_pkg::ID_W-1:0] id,
                                          logic [ptst_pkg::IVAL_W-1:0] ival,
                                          logic hnd, logic dstr);
    sched_req_t rq;
    rq.cmd  = cmd;
    rq.id   = id;
    rq.ival = ival;
    rq.hnd  = hnd;
    rq.dstr = dstr;
    return rq;
  endfunction

  function automatic sched_req_t random_request();
    sched_req_t  rq;
    int unsigned pick;
    rq.hnd  = ($urandom_range(99) < 75);
    rq.dstr = ($urandom_range(99) < 10);
    pick = $urandom_range(99);
    if (pick < 33)      rq.cmd = ptst_pkg::CMD_TICK;
    else if (pick < 78) rq.cmd = ptst_pkg::CMD_SET;
    else if (pick < 96) rq.cmd = ptst_pkg::CMD_QUERY;
    else                rq.cmd = CMD_UNUSED;
    // bias towards clients already in the table so updates and removes hit
    pick = $urandom_range(99);
    if (pick < 45 && tracker.slots_used != 0)
      rq.id = tracker.slot_client[$urandom_range(tracker.slots_used - 1)];
    else if (pick < 80)
      rq.id = id_pool[$urandom_range(ID_POOL - 1)];
    else
      rq.id = ptst_pkg::ID_W'($urandom);
    pick = $urandom_range(99);
    if (pick < 25)      rq.ival = '0;
    else if (pick < 65) rq.ival = ptst_pkg::IVAL_W'($urandom_range(4, 1));
    else if (pick < 75) rq.ival = {1'b1, (ptst_pkg::IVAL_W-1)'($urandom)};
    else                rq.ival = ptst_pkg::IVAL_W'($urandom);
    return rq;
  endfunction

  task automatic send_request(input sched_req_t rq);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid = 1'b0;
      @(negedge clk_i);
    end
    req_if.cmd          = rq.cmd;
    req_if.client_id    = rq.id;
    req_if.interval     = rq.ival;
    req_if.has_handler  = rq.hnd;
    req_if.is_destroyed = rq.dstr;
    req_if.valid        = 1'b1;
    do @(posedge clk_i); while (!req_if.ready);
    tracker.take_request(rq.cmd, rq.id, rq.ival, rq.hnd, rq.dstr);
  endtask

  task automatic send_random(input int count);
    sched_req_t rq;
    int         sent;
    sent = 0;
    while (sent < count) begin
      rq = random_request();
      send_request(rq);
      if (rq.cmd != CMD_UNUSED) sent++;
    end
  endtask

  // drop valid, wait for every reply, then let the block go quiet
  task automatic drain();
    @(negedge clk_i);
    req_if.valid = 1'b0;
    while (tracker.pending() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_beat(input logic on);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = on;
    @(posedge clk_i);
    tracker.beats_on = on;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // fill every slot with one-tick timers, try two more, then a full tick
  task automatic fill_table();
    sched_req_t rq;
    int         extra;
    extra = 0;
    while (tracker.slots_used < ENTRIES || extra < 2) begin
      rq = make_req(ptst_pkg::CMD_SET, ptst_pkg::ID_W'($urandom), ptst_pkg::IVAL_W'(1),
                    1'b1, 1'b0);
      if (tracker.find_slot(rq.id) < 0) begin
        if (tracker.slots_used == ENTRIES) extra++;
        send_request(rq);
      end
    end
    send_request(make_req(ptst_pkg::CMD_TICK, '0, '0, 1'b0, 1'b0));
  endtask

  initial begin
    req_if.valid        = 1'b0;
    req_if.cmd          = ptst_pkg::CMD_TICK;
    req_if.client_id    = '0;
    req_if.interval     = '0;
    req_if.has_handler  = 1'b0;
    req_if.is_destroyed = 1'b0;
    tracker    = new();
    id_pool[0] = '0;
    id_pool[1] = '1;
    for (int i = 2; i < ID_POOL; i++) id_pool[i] = ptst_pkg::ID_W'($urandom);

    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    write_beat(1'b1);

    // directed requests
    // empty table
    send_request(make_req(ptst_pkg::CMD_TICK,  16'h0000, 16'h0000, 1'b0, 1'b0));
    send_request(make_req(ptst_pkg::CMD_QUERY, 16'h0000, 16'h0000, 1'b0, 1'b0));
    // remove absent
    send_request(make_req(ptst_pkg::CMD_SET,   16'h0005, 16'h0000, 1'b0, 1'b0));
    // destroyed
    send_request(make_req(ptst_pkg::CMD_SET,   16'h0005, 16'h0003, 1'b1, 1'b1));
    send_request(make_req(ptst_pkg::CMD_SET,   16'h0000, 16'h0001, 1'b1, 1'b0));
    // negative new
    send_request(make_req(ptst_pkg::CMD_SET,   16'hFFFF, 16'h8000, 1'b1, 1'b0));
    send_request(make_req(ptst_pkg::CMD_SET,   16'h1234, 16'h7FFF, 1'b0, 1'b0));
    send_request(make_req(ptst_pkg::CMD_SET,   16'h00AA, 16'h0002, 1'b1, 1'b0));
    send_request(make_req(ptst_pkg::CMD_QUERY, 16'hFFFF, 16'h0000, 1'b0, 1'b0));
    // negative present
    send_request(make_req(ptst_pkg::CMD_SET,   16'h1234, 16'hFFFF, 1'b1, 1'b0));
    // update keeps handler
    send_request(make_req(ptst_pkg::CMD_SET,   16'h00AA, 16'h0003, 1'b0, 1'b0));
    send_request(make_req(ptst_pkg::CMD_TICK,  16'h0000, 16'h0000, 1'b0, 1'b0));
    send_request(make_req(ptst_pkg::CMD_TICK,  16'hFFFF, 16'hFFFF, 1'b1, 1'b1));
    send_request(make_req(ptst_pkg::CMD_TICK,  16'h0000, 16'h0000, 1'b0, 1'b0));
    // remove, compact
    send_request(make_req(ptst_pkg::CMD_SET,   16'hFFFF, 16'h0000, 1'b0, 1'b0));
    send_request(make_req(ptst_pkg::CMD_QUERY, 16'hFFFF, 16'h0000, 1'b0, 1'b0));
    send_request(make_req(CMD_UNUSED,          16'hFFFF, 16'hFFFF, 1'b1, 1'b1));
    send_request(make_req(ptst_pkg::CMD_TICK,  16'h0000, 16'h0000, 1'b0, 1'b0));
    send_request(make_req(ptst_pkg::CMD_QUERY, 16'h1234, 16'h0000, 1'b0, 1'b0));
    // destroyed remove
    send_request(make_req(ptst_pkg::CMD_SET,   16'h0000, 16'h0000, 1'b0, 1'b1));

    // back to back, then a full table
    send_random(15);
    fill_table();
    send_random(10);

    // beats off, sender idling
    drain();
    write_beat(1'b0);
    send_idle_pct = 69;
    send_random(15);

    // beats on, receiver stalling, with one long hold-off while requests keep coming
    drain();
    write_beat(1'b1);
    send_idle_pct = 0;
    res_stall_pct = 69;
    hold_res      = 1'b1;
    send_request(make_req(ptst_pkg::CMD_TICK, '0, '0, 1'b0, 1'b0));
    send_random(15);

    // both sides idling, with a pause until every reply is in
    send_idle_pct = 34;
    res_stall_pct = 34;
    send_random(12);
    drain();
    send_random(12);

    drain();
    if (tracker.bad_replies == 0 && tracker.pending() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
